// ----- rtl/hlpi_pkg.sv -----
// Shared constants and types for the hybrid level pressure interpolator.
package hlpi_pkg;

  // Fixed point formats.
  localparam int COEF_FRAC_BITS = 16;
  localparam int SAMPLE_WIDTH   = 32;
  localparam int COEF_W         = COEF_FRAC_BITS + 1;
  localparam int PS_W           = 17;
  localparam int TARGET_W       = 17;
  localparam int PRESS_W        = COEF_FRAC_BITS + 18;
  localparam int WEIGHT_BITS    = 16;
  localparam int WEIGHT_W       = WEIGHT_BITS + 1;

  // Reference pressure that scales coefficient A, in pascals.
  localparam int REF_PA_W = 17;
  localparam logic [REF_PA_W-1:0] REF_PA = REF_PA_W'(100000);

  // Target pressure after reset, in pascals.
  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(50000);

  // Serial unit widths.
  localparam int MAC_ACC_W   = PRESS_W + 1;
  localparam int MAC_CNT_W   = $clog2(COEF_W + 1);
  localparam int DIV_CNT_W   = $clog2(WEIGHT_W + 1);
  localparam int BLEND_ACC_W = SAMPLE_WIDTH + 1 + WEIGHT_W;
  localparam int BLEND_Q_W   = BLEND_ACC_W - WEIGHT_BITS;
  localparam logic [BLEND_ACC_W-1:0] ROUND_HALF = BLEND_ACC_W'(1) << (WEIGHT_BITS - 1);

  // Stream packing.
  localparam int IN_FIELDS_W = 2 * COEF_W + PS_W + SAMPLE_WIDTH;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  typedef logic [PRESS_W-1:0]             press_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [WEIGHT_W-1:0]            weight_t;

endpackage

// ----- rtl/hybrid_level_pressure_interp.sv -----
// Interpolates one column of hybrid sigma-pressure levels onto a target pressure.
// Levels enter top first, one transaction each; the column's last level (tlast) yields one
// output transaction carrying the interpolated value in tdata and the found flag in tuser.
// The level pressure comes from a bit-serial multiply-accumulate over the 17 coefficient
// bits, and the next level is taken only once the current one is through. A level that
// brackets the target also runs the 17-step serial divider for the weight and the
// 17-step serial blend with a rounding step and a final add. A finished result waits
// in the output register while the next column's levels are taken; only a second last
// level stalls until that register drains.
module hybrid_level_pressure_interp (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: target pressure in pascals.
  input  logic                            cfg_wr_en,
  input  logic [hlpi_pkg::TARGET_W-1:0]   cfg_wr_data,
  // Input levels.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata from bit 0: coef_a[16:0], coef_b[33:17], surface_pressure[50:34],
  // sample[82:51], zero fill to bit 87.
  input  logic [hlpi_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                            s_axis_tlast,  // last_level
  // Column results.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata from bit 0: interp_value[31:0].
  output logic [hlpi_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser   // found
);
  import hlpi_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRESS = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_BLEND = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam int A_LO = 0;
  localparam int B_LO = A_LO + COEF_W;
  localparam int P_LO = B_LO + COEF_W;
  localparam int S_LO = P_LO + PS_W;

  logic [2:0]          state;
  logic [TARGET_W-1:0] target;
  press_t              tp;
  press_t              prev_p;
  sample_t             prev_s;
  logic                have_prev;
  sample_t             held_value;
  logic                held_found;
  sample_t             cur_s;
  logic                cur_last;
  logic                out_valid;
  sample_t             out_data;
  logic                out_found;
  logic                out_free;
  logic                emit;
  logic                bracket;

  logic                mac_start;
  logic                mac_done;
  press_t              mac_p;
  logic                div_start;
  logic                div_done;
  weight_t             weight;
  logic                blend_start;
  logic                blend_done;
  sample_t             blend_value;

  // Target in pressure format, the bracketing test and the start and handshake strobes.
  always_comb begin
    tp          = PRESS_W'({target, {COEF_FRAC_BITS{1'b0}}});
    bracket     = have_prev && (prev_p < tp) && (mac_p >= tp);
    out_free    = !out_valid || m_axis_tready;
    emit        = (state == ST_FIN) && cur_last && out_free;
    mac_start   = (state == ST_IDLE) && s_axis_tvalid;
    div_start   = (state == ST_PRESS) && mac_done && bracket;
    blend_start = (state == ST_DIV) && div_done;
  end

  hlpi_press_mac u_mac (
    .clk              (clk),
    .rst              (rst),
    .start            (mac_start),
    .coef_a           (s_axis_tdata[A_LO +: COEF_W]),
    .coef_b           (s_axis_tdata[B_LO +: COEF_W]),
    .surface_pressure (s_axis_tdata[P_LO +: PS_W]),
    .done             (mac_done),
    .pressure         (mac_p)
  );

  hlpi_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .p_cur  (mac_p),
    .p_prev (prev_p),
    .p_tgt  (tp),
    .done   (div_done),
    .weight (weight)
  );

  hlpi_blend u_blend (
    .clk    (clk),
    .rst    (rst),
    .start  (blend_start),
    .weight (weight),
    .s_prev (prev_s),
    .s_cur  (cur_s),
    .done   (blend_done),
    .value  (blend_value)
  );

  // Control: sequencer, column flags, output valid and the target register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      have_prev  <= 1'b0;
      held_found <= 1'b0;
      out_valid  <= 1'b0;
      target     <= TARGET_RESET;
    end else begin
      if (cfg_wr_en) begin
        target <= cfg_wr_data;
      end
      // A new result may replace one that drains in the same cycle.
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_PRESS;
          end
        end
        ST_PRESS: begin
          if (mac_done) begin
            state <= bracket ? ST_DIV : ST_FIN;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          if (blend_done) begin
            held_found <= 1'b1;
            state      <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!cur_last) begin
            have_prev <= 1'b1;
            state     <= ST_IDLE;
          end else if (out_free) begin
            have_prev  <= 1'b0;
            held_found <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (mac_start) begin
      cur_s    <= s_axis_tdata[S_LO +: SAMPLE_WIDTH];
      cur_last <= s_axis_tlast;
    end
    if (state == ST_BLEND && blend_done) begin
      held_value <= blend_value;
    end
    if (state == ST_FIN) begin
      prev_p <= mac_p;
      prev_s <= cur_s;
      if (cur_last && out_free) begin
        out_data  <= held_found ? held_value : '0;
        out_found <= held_found;
      end
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data);
  assign m_axis_tuser  = out_found;

endmodule

// ----- rtl/hlpi_press_mac.sv -----
// Bit-serial level pressure unit: 100000*A + PS*B, one coefficient bit per cycle.
module hlpi_press_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hlpi_pkg::COEF_W-1:0] coef_a,
  input  logic [hlpi_pkg::COEF_W-1:0] coef_b,
  input  logic [hlpi_pkg::PS_W-1:0]   surface_pressure,
  output logic                       done,
  output hlpi_pkg::press_t           pressure
);
  import hlpi_pkg::*;

  logic [COEF_W-1:0]    a_sr;
  logic [COEF_W-1:0]    b_sr;
  logic [PS_W-1:0]      ps;
  logic [MAC_ACC_W-1:0] acc;
  logic [MAC_ACC_W-1:0] acc_next;
  logic [MAC_CNT_W-1:0] cnt;
  logic                 busy;

  // Horner step: double the partial sum and add the terms selected by the top bits.
  always_comb begin
    acc_next = {acc[MAC_ACC_W-2:0], 1'b0}
             + (a_sr[COEF_W-1] ? MAC_ACC_W'(REF_PA) : '0)
             + (b_sr[COEF_W-1] ? MAC_ACC_W'(ps) : '0);
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MAC_CNT_W'(COEF_W);
      end else if (busy) begin
        cnt <= cnt - MAC_CNT_W'(1);
        if (cnt == MAC_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand shift registers and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      a_sr <= coef_a;
      b_sr <= coef_b;
      ps   <= surface_pressure;
      acc  <= '0;
    end else if (busy) begin
      a_sr <= {a_sr[COEF_W-2:0], 1'b0};
      b_sr <= {b_sr[COEF_W-2:0], 1'b0};
      acc  <= acc_next;
    end
  end

  // Saturate to the largest representable pressure.
  assign pressure = acc[MAC_ACC_W-1] ? '1 : acc[PRESS_W-1:0];

endmodule

// ----- rtl/hlpi_div.sv -----
// Restoring divider that forms the Q1.16 weight one quotient bit per cycle.
module hlpi_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hlpi_pkg::press_t  p_cur,
  input  hlpi_pkg::press_t  p_prev,
  input  hlpi_pkg::press_t  p_tgt,
  output logic              done,
  output hlpi_pkg::weight_t weight
);
  import hlpi_pkg::*;

  logic [PRESS_W:0]     rem;
  logic [PRESS_W:0]     diff;
  logic [PRESS_W:0]     rem_sel;
  logic                 ge;
  press_t               den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;

  // One quotient bit: compare, conditionally subtract, shift.
  always_comb begin
    ge      = rem >= {1'b0, den};
    diff    = rem - {1'b0, den};
    rem_sel = ge ? diff : rem;
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(WEIGHT_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient registers. The numerator never exceeds the divisor,
  // so the first bit is the integer part of the weight.
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= {1'b0, p_tgt - p_prev};
      den    <= p_cur - p_prev;
      weight <= '0;
    end else if (busy) begin
      rem    <= {rem_sel[PRESS_W-1:0], 1'b0};
      weight <= {weight[WEIGHT_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/hlpi_blend.sv -----
// Serial blend: s_prev + round(w * (s_cur - s_prev) / 65536), one weight bit per cycle.
module hlpi_blend (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hlpi_pkg::weight_t weight,
  input  hlpi_pkg::sample_t s_prev,
  input  hlpi_pkg::sample_t s_cur,
  output logic              done,
  output hlpi_pkg::sample_t value
);
  import hlpi_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_RND  = 2'd2;
  localparam logic [1:0] PH_ADD  = 2'd3;

  logic [1:0]                    phase;
  logic [DIV_CNT_W-1:0]          cnt;
  weight_t                       w_sr;
  sample_t                       sp;
  logic signed [SAMPLE_WIDTH:0]  d;
  logic signed [BLEND_ACC_W-1:0] d_ext;
  logic [BLEND_ACC_W-1:0]        acc;
  logic [BLEND_ACC_W-1:0]        acc_next;
  logic [BLEND_ACC_W-1:0]        rnd;
  logic [BLEND_Q_W-1:0]          q;

  // Shift-add on the signed difference, then round half up.
  always_comb begin
    d_ext    = BLEND_ACC_W'(d);
    acc_next = {acc[BLEND_ACC_W-2:0], 1'b0} + (w_sr[WEIGHT_W-1] ? d_ext : '0);
    rnd      = acc + ROUND_HALF;
  end

  // Phase sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_MUL;
            cnt   <= DIV_CNT_W'(WEIGHT_W);
          end
        end
        PH_MUL: begin
          cnt <= cnt - DIV_CNT_W'(1);
          if (cnt == DIV_CNT_W'(1)) begin
            phase <= PH_RND;
          end
        end
        PH_RND: begin
          phase <= PH_ADD;
        end
        PH_ADD: begin
          phase <= PH_IDLE;
          done  <= 1'b1;
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start && phase == PH_IDLE) begin
      w_sr <= weight;
      sp   <= s_prev;
      d    <= {s_cur[SAMPLE_WIDTH-1], s_cur} - {s_prev[SAMPLE_WIDTH-1], s_prev};
      acc  <= '0;
    end else if (phase == PH_MUL) begin
      w_sr <= {w_sr[WEIGHT_W-2:0], 1'b0};
      acc  <= acc_next;
    end
    if (phase == PH_RND) begin
      q <= rnd[BLEND_ACC_W-1:WEIGHT_BITS];
    end
    // The result lies between the two samples, so the low bits suffice.
    if (phase == PH_ADD) begin
      value <= sp + sample_t'(q[SAMPLE_WIDTH-1:0]);
    end
  end

endmodule

// ----- rtl/hlpi_checker.sv -----
// Port-level checks for the interpolator, bound to the top level.
module hlpi_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_wr_en,
  input logic [hlpi_pkg::TARGET_W-1:0]    cfg_wr_data,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [hlpi_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [hlpi_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser
);
  import hlpi_pkg::*;

  logic in_acc;
  logic cfg_seen;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cfg_seen = cfg_wr_en && (cfg_wr_data != '0 || cfg_wr_data == '0);

  // A result waiting for the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction dropped before it was taken");

  // Levels are worked one at a time, so the input closes right after a transaction.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("input taken again while a level is still in work");

  // A column without a bracketing pair reports a zero value.
  a_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("value nonzero although no bracketing pair was found");

  // A new result never appears in the cycle right after an input transaction.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) && !cfg_seen |-> !$past(in_acc))
    else $error("result appeared before the level pressure was formed");

endmodule

bind hybrid_level_pressure_interp hlpi_checker u_hlpi_checker (.*);

// ----- test/hybrid_level_pressure_interp_test.sv -----
// Self-checking testbench for the hybrid level pressure interpolator.
`timescale 1ns / 100ps

module hybrid_level_pressure_interp_test;
  import hlpi_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF       = 80;
  localparam int PHASES         = 8;
  localparam int PHASE_LEVELS   = 141;
  localparam int DIR_ROWS       = 24;
  localparam longint unsigned PRESS_MAX = (64'd1 << PRESS_W) - 64'd1;
  localparam longint unsigned WEIGHT_ONE = 64'd1 << WEIGHT_BITS;

  // One column level as it enters, and one column result as it leaves.
  typedef struct {
    logic [COEF_W-1:0] coef_a;
    logic [COEF_W-1:0] coef_b;
    logic [PS_W-1:0]   surf;
    sample_t           sample;
    logic              last;
  } level_t;

  typedef struct {
    sample_t value;
    logic    found;
  } column_result_t;

  // Directed row: a level plus an optional hand-written result.
  typedef struct {
    logic [COEF_W-1:0] coef_a;
    logic [COEF_W-1:0] coef_b;
    logic [PS_W-1:0]   surf;
    sample_t           sample;
    logic              last;
    bit                typed;
    sample_t           exp_value;
    logic              exp_found;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [TARGET_W-1:0]     cfg_wr_data;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata;
  logic                    s_axis_tlast;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tuser;

  hybrid_level_pressure_interp dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the column being collected and the target setting.
  logic [TARGET_W-1:0] col_target;
  press_t              prev_press;
  sample_t             prev_sample;
  bit                  have_prev;
  sample_t             held_value;
  bit                  held_found;

  column_result_t pending_columns[$];
  int fail_count;
  int levels_sent;
  int results_checked;
  int found_count;
  int src_idle_pct;
  int sink_stall_pct;
  int quiet_cycles;

  // Hand-picked levels at the reset target of 50000 Pa.
  dir_row_t dir_rows [DIR_ROWS] = '{
    // A column of one level has no pair.
    '{17'd0, 17'd65536, 17'd101325, 32'sd12345, 1'b1, 1'b1, 32'sd0, 1'b0},
    // Both levels stay above the target level.
    '{17'd0, 17'd0, 17'd0, 32'sd7, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{17'd0, 17'd32768, 17'd90000, -32'sd9, 1'b1, 1'b1, 32'sd0, 1'b0},
    // The lower level lands exactly on the target: the full weight goes to it.
    '{17'd0, 17'd0, 17'd0, 32'sd100, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{17'd0, 17'd65536, 17'd50000, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1},
    '{17'd0, 17'd0, 17'd0, 32'h8000_0000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{17'd0, 17'd65536, 17'd50000, 32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff, 1'b1},
    // The first level is already below the target, so nothing brackets.
    '{17'd0, 17'd65536, 17'd60000, 32'sd11, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{17'd0, 17'd65536, 17'd70000, 32'sd22, 1'b1, 1'b1, 32'sd0, 1'b0},
    // A level exactly at the target is not above it.
    '{17'd0, 17'd65536, 17'd50000, 32'sd33, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{17'd0, 17'd65536, 17'd131071, 32'sd44, 1'b1, 1'b1, 32'sd0, 1'b0},
    // Largest in-range coefficients and surface pressure with sample extremes.
    '{17'd0, 17'd0, 17'd0, 32'h8000_0000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{17'd65536, 17'd65536, 17'd131071, 32'h7fff_ffff, 1'b1, 1'b0, 32'sd0, 1'b0},
    // Coefficients beyond one saturate the level pressure.
    '{17'd0, 17'd16384, 17'd131071, -32'sd500000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{17'd131071, 17'd131071, 17'd131071, 32'sd900000, 1'b1, 1'b0, 32'sd0, 1'b0},
    // Pressure rises, falls and rises again; the later bracketing pair wins.
    '{17'd0, 17'd65536, 17'd20000, 32'sd1000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{17'd0, 17'd65536, 17'd60000, 32'sd2000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{17'd0, 17'd65536, 17'd30000, -32'sd5000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{17'd0, 17'd65536, 17'd70000, 32'sd8000, 1'b1, 1'b0, 32'sd0, 1'b0},
    // Both coefficients in use, weight with a remainder.
    '{17'd1000, 17'd20000, 17'd101325, -32'sd77777, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{17'd20000, 17'd40000, 17'd101325, 32'sd123457, 1'b1, 1'b0, 32'sd0, 1'b0},
    // Bracket in the middle of the column, nothing after it.
    '{17'd0, 17'd0, 17'd0, -32'sd3, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{17'd0, 17'd65536, 17'd80000, 32'sd4, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{17'd0, 17'd65536, 17'd90000, 32'sd99, 1'b1, 1'b0, 32'sd0, 1'b0}
  };

  // Advance the column state by one level; a last level yields a result.
  function automatic void interpolate_level(input level_t lv, output bit emits,
                                            output column_result_t res);
    longint unsigned p_full;
    longint unsigned target_fx;
    longint unsigned num;
    longint unsigned den;
    longint unsigned w;
    longint          acc;
    press_t          p;
    p_full = 64'd100000 * 64'(lv.coef_a) + 64'(lv.surf) * 64'(lv.coef_b);
    p = (p_full > PRESS_MAX) ? press_t'(PRESS_MAX) : press_t'(p_full);
    target_fx = 64'(col_target) << COEF_FRAC_BITS;
    if (have_prev && 64'(prev_press) < target_fx && 64'(p) >= target_fx) begin
      num = (target_fx - 64'(prev_press)) << WEIGHT_BITS;
      den = 64'(p) - 64'(prev_press);
      w = num / den;
      if (w > WEIGHT_ONE) w = WEIGHT_ONE;
      acc = longint'(w) * longint'(lv.sample)
          + longint'(WEIGHT_ONE - w) * longint'(prev_sample)
          + longint'(WEIGHT_ONE >> 1);
      held_value = sample_t'(acc >>> WEIGHT_BITS);
      held_found = 1'b1;
    end
    prev_press  = p;
    prev_sample = lv.sample;
    have_prev   = 1'b1;
    emits = lv.last;
    res.value = held_found ? held_value : '0;
    res.found = held_found;
    if (lv.last) begin
      prev_press  = '0;
      prev_sample = '0;
      have_prev   = 1'b0;
      held_value  = '0;
      held_found  = 1'b0;
    end
  endfunction

  // Offer one level, with random idle cycles in front, and record its outcome.
  task automatic push_level(input level_t lv, input bit typed, input column_result_t typed_res);
    bit             emits;
    column_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({lv.sample, lv.surf, lv.coef_b, lv.coef_a});
    s_axis_tlast  <= lv.last;
    do @(posedge clk); while (!s_axis_tready);
    interpolate_level(lv, emits, res);
    if (emits) pending_columns.push_back(typed ? typed_res : res);
    levels_sent++;
    @(negedge clk);
  endtask

  // Drain every outstanding column, then let the block go quiet.
  task automatic settle_columns();
    s_axis_tvalid <= 1'b0;
    while (pending_columns.size() != 0) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);
  endtask

  task automatic write_target(input logic [TARGET_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    col_target  = value;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    if ($urandom_range(9) == 0) return COEF_W'($urandom_range(0, 131071));
    return COEF_W'($urandom_range(0, 65536));
  endfunction

  // A column is mostly a rising pressure profile; some are pure noise.
  task automatic send_column(output int sent);
    int              n;
    int              b;
    int              surf;
    bit              noisy;
    level_t          lv;
    column_result_t  none;
    none  = '{value: '0, found: 1'b0};
    noisy = ($urandom_range(4) == 0);
    n     = noisy ? $urandom_range(1, 5) : $urandom_range(1, 8);
    if ($urandom_range(9) < 3) surf = $urandom_range(0, 131071);
    else surf = $urandom_range(int'(col_target), 131071);
    for (int k = 0; k < n; k++) begin
      if (noisy) begin
        lv.coef_a = pick_coef();
        lv.coef_b = pick_coef();
        lv.surf   = PS_W'($urandom_range(0, 131071));
      end else begin
        b = (n > 1) ? (k * 65536) / (n - 1) : $urandom_range(0, 65536);
        b += $urandom_range(0, 1500);
        if (b > 65536) b = 65536;
        lv.coef_a = COEF_W'($urandom_range(0, 3000));
        lv.coef_b = COEF_W'(b);
        lv.surf   = PS_W'(surf);
      end
      lv.sample = pick_sample();
      lv.last   = (k == n - 1);
      push_level(lv, 1'b0, none);
    end
    sent = n;
  endtask

  // Result checker: every output transaction against the oldest pending column.
  always @(posedge clk) begin
    column_result_t want;
    sample_t        got_value;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_value = sample_t'(m_axis_tdata[SAMPLE_WIDTH-1:0]);
      if (pending_columns.size() == 0) begin
        $error("unexpected result: interp_value %0d found %0b", got_value, m_axis_tuser);
        fail_count++;
      end else begin
        want = pending_columns.pop_front();
        results_checked++;
        if (want.found) found_count++;
        if (got_value !== want.value) begin
          $error("interp_value: expected %0d, got %0d", want.value, got_value);
          fail_count++;
        end
        if (m_axis_tuser !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // Output back-pressure, redrawn each cycle.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: too long without any transaction ends the run.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d columns pending", pending_columns.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int                   phase_levels;
    int                   sent;
    level_t               lv;
    column_result_t       typed_res;
    logic [TARGET_W-1:0]  targets [PHASES];
    int                   src_pcts [4];
    int                   sink_pcts [4];
    targets   = '{17'd131071, 17'd0, 17'd50000, 17'd101325, 17'd1, 17'd85000,
                  17'd131070, 17'd0};
    src_pcts  = '{0, 71, 0, 22};
    sink_pcts = '{0, 0, 71, 22};
    targets[5] = TARGET_W'($urandom_range(20000, 110000));
    fail_count = 0;
    levels_sent = 0;
    results_checked = 0;
    found_count = 0;
    quiet_cycles = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    col_target  = TARGET_RESET;
    prev_press  = '0;
    prev_sample = '0;
    have_prev   = 1'b0;
    held_value  = '0;
    held_found  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed columns at the reset target.
    foreach (dir_rows[i]) begin
      lv.coef_a = dir_rows[i].coef_a;
      lv.coef_b = dir_rows[i].coef_b;
      lv.surf   = dir_rows[i].surf;
      lv.sample = dir_rows[i].sample;
      lv.last   = dir_rows[i].last;
      typed_res.value = dir_rows[i].exp_value;
      typed_res.found = dir_rows[i].exp_found;
      push_level(lv, dir_rows[i].typed, typed_res);
    end
    settle_columns();

    // Random columns, one target and one idling pattern per phase.
    for (int ph = 0; ph < PHASES; ph++) begin
      src_idle_pct   = src_pcts[ph % 4];
      sink_stall_pct = sink_pcts[ph % 4];
      write_target(targets[ph]);
      phase_levels = 0;
      while (phase_levels < PHASE_LEVELS) begin
        send_column(sent);
        phase_levels += sent;
      end
      settle_columns();
    end

    $display("Sent %0d levels over %0d target settings; checked %0d column results,",
             levels_sent, PHASES + 1, results_checked);
    $display("%0d of them with a bracketing pair found.", found_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
